// File: rtl/core/tsi_pkg.sv
// ----------------------------------------------------------------------------
// tsi_pkg
// Shared widths, codes and payload types of the two-axis step interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tsi_pkg;

  localparam int POSITION_BITS   = 24;
  localparam int STEP_COUNT_BITS = 16;
  localparam int DELAY_BITS      = 8;
  localparam int STATUS_BITS     = 3;

  localparam int CFG_DATA_BITS   = 32;
  localparam int CFG_ADDR_BITS   = 4;
  localparam int CFG_INDEX_BITS  = 2;

  localparam int MAX_MOVE_BITS   = 16;

  localparam logic [MAX_MOVE_BITS-1:0] MAX_MOVE_RESET  = MAX_MOVE_BITS'(5000);
  localparam logic [DELAY_BITS-1:0]    MIN_DELAY_RESET = DELAY_BITS'(3);
  localparam logic [DELAY_BITS-1:0]    MAX_DELAY_RESET = DELAY_BITS'(40);

  // largest delta that the step counters can hold
  localparam logic [31:0] CNT_MAX = 32'((64'd1 << STEP_COUNT_BITS) - 64'd1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAX_MOVE_STEPS = 2'd0,
    REG_MIN_STEP_DELAY = 2'd1,
    REG_MAX_STEP_DELAY = 2'd2
  } reg_index_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_NONE      = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_NO_MOVE   = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_BUSY      = 3'd4
  } status_t;

  typedef struct packed {
    logic                     opcode;
    logic [POSITION_BITS-1:0] left_target;
    logic [POSITION_BITS-1:0] right_target;
    logic [DELAY_BITS-1:0]    step_delay;
  } cmd_t;

  typedef struct packed {
    logic                   left_step;
    logic                   right_step;
    logic                   left_backward;
    logic                   right_backward;
    logic                   busy_res;
    logic                   move_done;
    logic [STATUS_BITS-1:0] status;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/core/tsi_if.sv
// ----------------------------------------------------------------------------
// tsi_if
// Command and result channels of the step interpolator, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsi_cmd_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [tsi_pkg::POSITION_BITS-1:0] left_target;
  logic [tsi_pkg::POSITION_BITS-1:0] right_target;
  logic [tsi_pkg::DELAY_BITS-1:0]    step_delay;

  modport source (output valid, output opcode, output left_target,
                  output right_target, output step_delay, input ready);
  modport sink   (input valid, input opcode, input left_target,
                  input right_target, input step_delay, output ready);
endinterface

interface tsi_res_if;
  logic                            valid;
  logic                            ready;
  logic                            left_step;
  logic                            right_step;
  logic                            left_backward;
  logic                            right_backward;
  logic                            busy_res;
  logic                            move_done;
  logic [tsi_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, output left_step, output right_step,
                  output left_backward, output right_backward, output busy_res,
                  output move_done, output status, input ready);
  modport sink   (input valid, input left_step, input right_step,
                  input left_backward, input right_backward, input busy_res,
                  input move_done, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/core/two_axis_step_interpolator.sv
// ----------------------------------------------------------------------------
// two_axis_step_interpolator
// Bresenham-style two-axis stepper interpolator driven by move and tick items.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries commands: opcode start (absolute left/right targets and a
//   requested delay in ticks) or tick (one millisecond). Every command gives
//   exactly one result on out_if: step pulses, directions, busy, done, status.
//   The APB port (psel/penable/pwrite/paddr/pwdata) holds the move limit and
//   the delay clamp range at byte addresses 0, 4 and 8; write it while idle.
//   An accepted command is captured in an input register, evaluated against
//   the motion state in one pass and lands in the result register that
//   drives out_if. One command is taken per cycle, sustained while the
//   receiver keeps up, since each tick is one accumulate-compare per axis.
//   If the receiver stalls, the held result stays put and one more command
//   can still be taken into the input register; in_if.ready then drops.
//   Synchronous reset (rst_n low) clears positions, the move in progress and
//   both pipeline stages, and loads the register reset values 5000, 3, 40.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_step_interpolator (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  tsi_cmd_if.sink                                 in_if,
  tsi_res_if.source                               out_if,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [tsi_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire logic [tsi_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic      [tsi_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                    pready
);

  localparam int PB = tsi_pkg::POSITION_BITS;
  localparam int CB = tsi_pkg::STEP_COUNT_BITS;
  localparam int DB = tsi_pkg::DELAY_BITS;
  localparam int MB = tsi_pkg::MAX_MOVE_BITS;

  // configuration
  logic [MB-1:0] max_move_r;
  logic [DB-1:0] min_delay_r;
  logic [DB-1:0] max_delay_r;
  logic          cfg_wr;
  tsi_pkg::reg_index_t cfg_idx;

  // pipeline
  logic          s1_vld_r;
  tsi_pkg::cmd_t cmd_r;
  logic          out_vld_r;
  tsi_pkg::res_t res_r;
  tsi_pkg::res_t res_nxt;
  logic          out_take;
  logic          s1_fire;
  logic          in_fire;

  // motion state
  logic [PB-1:0]  lpos_r, lpos_nxt, rpos_r, rpos_nxt;
  logic [PB-1:0]  lgoal_r, lgoal_nxt, rgoal_r, rgoal_nxt;
  logic [CB-1:0]  ldelta_r, ldelta_nxt, rdelta_r, rdelta_nxt;
  logic [CB-1:0]  longest_r, longest_nxt;
  logic [CB-1:0]  lacc_r, lacc_nxt, racc_r, racc_nxt;
  logic [CB-1:0]  iter_r, iter_nxt;
  logic [DB-1:0]  wait_r, wait_nxt;
  logic [DB-1:0]  delay_r, delay_nxt;
  logic [1:0]     dir_r, dir_nxt;
  logic           moving_r, moving_nxt;

  // start evaluation
  logic           lback, rback;
  logic [PB-1:0]  labs, rabs;
  logic           too_large;
  logic [DB-1:0]  dly_lo, dly_clamp;
  logic [CB-1:0]  la_cnt, ra_cnt;
  // tick evaluation
  logic [CB:0]    lsum, rsum;
  logic           lhit, rhit;
  tsi_pkg::status_t status;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = tsi_pkg::reg_index_t'(paddr[tsi_pkg::CFG_ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      tsi_pkg::REG_MAX_MOVE_STEPS: prdata = tsi_pkg::CFG_DATA_BITS'(max_move_r);
      tsi_pkg::REG_MIN_STEP_DELAY: prdata = tsi_pkg::CFG_DATA_BITS'(min_delay_r);
      tsi_pkg::REG_MAX_STEP_DELAY: prdata = tsi_pkg::CFG_DATA_BITS'(max_delay_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_move_r  <= tsi_pkg::MAX_MOVE_RESET;
      min_delay_r <= tsi_pkg::MIN_DELAY_RESET;
      max_delay_r <= tsi_pkg::MAX_DELAY_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        tsi_pkg::REG_MAX_MOVE_STEPS: max_move_r  <= pwdata[MB-1:0];
        tsi_pkg::REG_MIN_STEP_DELAY: min_delay_r <= pwdata[DB-1:0];
        tsi_pkg::REG_MAX_STEP_DELAY: max_delay_r <= pwdata[DB-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  assign out_take    = !out_vld_r || out_if.ready;
  assign s1_fire     = s1_vld_r && out_take;
  assign in_if.ready = !s1_vld_r || out_take;
  assign in_fire     = in_if.valid && in_if.ready;

  // --------------------------------------------------------------------------
  // start: deltas, limit check, delay clamp
  // --------------------------------------------------------------------------
  always_comb begin
    lback = cmd_r.left_target < lpos_r;
    rback = cmd_r.right_target < rpos_r;
    labs  = lback ? (lpos_r - cmd_r.left_target) : (cmd_r.left_target - lpos_r);
    rabs  = rback ? (rpos_r - cmd_r.right_target) : (cmd_r.right_target - rpos_r);
    too_large = (32'(labs) > 32'(max_move_r)) || (32'(rabs) > 32'(max_move_r)) ||
                (32'(labs) > tsi_pkg::CNT_MAX) || (32'(rabs) > tsi_pkg::CNT_MAX);
    la_cnt = CB'(labs);
    ra_cnt = CB'(rabs);
    // max clamp wins when the range is inverted
    dly_lo    = (cmd_r.step_delay < min_delay_r) ? min_delay_r : cmd_r.step_delay;
    dly_clamp = (dly_lo > max_delay_r) ? max_delay_r : dly_lo;
    if (dly_clamp == '0) begin
      dly_clamp = DB'(1);
    end
  end

  // --------------------------------------------------------------------------
  // tick: one dda iteration per axis
  // --------------------------------------------------------------------------
  always_comb begin
    lsum = {1'b0, lacc_r} + {1'b0, ldelta_r};
    rsum = {1'b0, racc_r} + {1'b0, rdelta_r};
    lhit = lsum >= {1'b0, longest_r};
    rhit = rsum >= {1'b0, longest_r};
  end

  always_comb begin
    lpos_nxt    = lpos_r;
    rpos_nxt    = rpos_r;
    lgoal_nxt   = lgoal_r;
    rgoal_nxt   = rgoal_r;
    ldelta_nxt  = ldelta_r;
    rdelta_nxt  = rdelta_r;
    longest_nxt = longest_r;
    lacc_nxt    = lacc_r;
    racc_nxt    = racc_r;
    iter_nxt    = iter_r;
    wait_nxt    = wait_r;
    delay_nxt   = delay_r;
    dir_nxt     = dir_r;
    moving_nxt  = moving_r;
    status      = tsi_pkg::ST_NONE;
    res_nxt     = '0;

    if (cmd_r.opcode == tsi_pkg::OP_START) begin
      priority if (moving_r) begin
        status = tsi_pkg::ST_BUSY;
      end else if (too_large) begin
        status = tsi_pkg::ST_TOO_LARGE;
      end else if (labs == '0 && rabs == '0) begin
        status = tsi_pkg::ST_NO_MOVE;
      end else begin
        status      = tsi_pkg::ST_ACCEPTED;
        lgoal_nxt   = cmd_r.left_target;
        rgoal_nxt   = cmd_r.right_target;
        ldelta_nxt  = la_cnt;
        rdelta_nxt  = ra_cnt;
        longest_nxt = (la_cnt > ra_cnt) ? la_cnt : ra_cnt;
        lacc_nxt    = '0;
        racc_nxt    = '0;
        iter_nxt    = (la_cnt > ra_cnt) ? la_cnt : ra_cnt;
        wait_nxt    = '0;
        delay_nxt   = dly_clamp;
        dir_nxt     = {rback, lback};
        moving_nxt  = 1'b1;
      end
    end else if (moving_r) begin
      priority if (wait_r != '0) begin
        wait_nxt = wait_r - DB'(1);
      end else if (iter_r == '0) begin
        lpos_nxt          = lgoal_r;
        rpos_nxt          = rgoal_r;
        moving_nxt        = 1'b0;
        res_nxt.move_done = 1'b1;
      end else begin
        lacc_nxt           = lhit ? CB'(lsum - {1'b0, longest_r}) : lsum[CB-1:0];
        racc_nxt           = rhit ? CB'(rsum - {1'b0, longest_r}) : rsum[CB-1:0];
        res_nxt.left_step  = lhit;
        res_nxt.right_step = rhit;
        iter_nxt           = iter_r - CB'(1);
        wait_nxt           = delay_r - DB'(1);
      end
    end

    res_nxt.left_backward  = dir_nxt[0];
    res_nxt.right_backward = dir_nxt[1];
    res_nxt.busy_res       = moving_nxt;
    res_nxt.status         = status;
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      lpos_r    <= '0;
      rpos_r    <= '0;
      lgoal_r   <= '0;
      rgoal_r   <= '0;
      ldelta_r  <= '0;
      rdelta_r  <= '0;
      longest_r <= '0;
      lacc_r    <= '0;
      racc_r    <= '0;
      iter_r    <= '0;
      wait_r    <= '0;
      delay_r   <= '0;
      dir_r     <= '0;
      moving_r  <= 1'b0;
    end else begin
      if (in_if.ready) begin
        s1_vld_r <= in_if.valid;
      end
      if (out_take) begin
        out_vld_r <= s1_vld_r;
      end
      if (s1_fire) begin
        lpos_r    <= lpos_nxt;
        rpos_r    <= rpos_nxt;
        lgoal_r   <= lgoal_nxt;
        rgoal_r   <= rgoal_nxt;
        ldelta_r  <= ldelta_nxt;
        rdelta_r  <= rdelta_nxt;
        longest_r <= longest_nxt;
        lacc_r    <= lacc_nxt;
        racc_r    <= racc_nxt;
        iter_r    <= iter_nxt;
        wait_r    <= wait_nxt;
        delay_r   <= delay_nxt;
        dir_r     <= dir_nxt;
        moving_r  <= moving_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r.opcode       <= in_if.opcode;
      cmd_r.left_target  <= in_if.left_target;
      cmd_r.right_target <= in_if.right_target;
      cmd_r.step_delay   <= in_if.step_delay;
    end
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.left_step      = res_r.left_step;
  assign out_if.right_step     = res_r.right_step;
  assign out_if.left_backward  = res_r.left_backward;
  assign out_if.right_backward = res_r.right_backward;
  assign out_if.busy_res       = res_r.busy_res;
  assign out_if.move_done      = res_r.move_done;
  assign out_if.status         = res_r.status;

endmodule

`default_nettype wire

// File: rtl/core/tsi_checker.sv
// ----------------------------------------------------------------------------
// tsi_checker
// Port-level assertions of the step interpolator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsi_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic                            left_step,
  input wire logic                            right_step,
  input wire logic                            busy_res,
  input wire logic                            move_done,
  input wire logic [tsi_pkg::STATUS_BITS-1:0] status
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({left_step, right_step, busy_res, move_done, status}))
    else $error("result changed while stalled");

  // finishing a move ends busy and carries no status or steps
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && move_done |->
      !busy_res && status == tsi_pkg::ST_NONE && !left_step && !right_step)
    else $error("move_done with busy, status or steps");

  // steps only come from ticks of a move that is still running
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (left_step || right_step) |->
      busy_res && status == tsi_pkg::ST_NONE)
    else $error("step pulse outside a running move");

  // an accepted or refused-busy start leaves the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == tsi_pkg::ST_ACCEPTED || status == tsi_pkg::ST_BUSY) |->
      busy_res)
    else $error("start accepted or refused busy but block idle");

endmodule

bind two_axis_step_interpolator tsi_checker u_tsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .left_step  (out_if.left_step),
  .right_step (out_if.right_step),
  .busy_res   (out_if.busy_res),
  .move_done  (out_if.move_done),
  .status     (out_if.status)
);

`default_nettype wire

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the two-axis step interpolator against an in-bench motion predictor.
// Commands are queued ahead of time, driven with random gaps and checked
// in order on the result channel; the limit and delay registers are
// rewritten between phases and read back.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = tsi_pkg::POSITION_BITS;
  localparam int CB = tsi_pkg::STEP_COUNT_BITS;
  localparam int DB = tsi_pkg::DELAY_BITS;
  localparam int MB = tsi_pkg::MAX_MOVE_BITS;

  typedef struct {
    logic [PB-1:0] lpos, rpos, lgoal, rgoal;
    logic [CB-1:0] ldelta, rdelta, longest, lacc, racc, iters;
    logic [DB-1:0] wait_cnt, delay;
    logic [1:0]    dir;
    logic          moving;
  } motion_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                              psel, penable, pwrite, pready;
  logic [tsi_pkg::CFG_ADDR_BITS-1:0] paddr;
  logic [tsi_pkg::CFG_DATA_BITS-1:0] pwdata, prdata;

  tsi_cmd_if cmd_ch ();
  tsi_res_if res_ch ();

  two_axis_step_interpolator uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (cmd_ch),
    .out_if  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // register copies shared by the planner and the live predictor
  logic [MB-1:0] cfg_max_move;
  logic [DB-1:0] cfg_min_delay, cfg_max_delay;

  motion_t live_motion;   // follows the commands the block has taken
  motion_t plan_motion;   // follows the commands queued so far

  tsi_pkg::cmd_t cmd_backlog[$];
  tsi_pkg::res_t motor_results_due[$];
  int   queued_cmds = 0;
  int   cmds_taken = 0;
  int   bad_fields = 0;
  int   src_gap = 0;
  int   snk_gap = 0;
  bit   idle_on = 1'b1;
  bit   hold_off = 1'b0;

  function automatic logic [DB-1:0] clamp_delay(logic [DB-1:0] req);
    logic [DB-1:0] d;
    d = req;
    if (d < cfg_min_delay) d = cfg_min_delay;
    if (d > cfg_max_delay) d = cfg_max_delay;
    if (d == '0) d = 1;
    return d;
  endfunction

  function automatic tsi_pkg::res_t interpolate_item(ref motion_t m, input tsi_pkg::cmd_t c);
    tsi_pkg::res_t r;
    logic [PB-1:0] ldist, rdist;
    logic          lback, rback;
    logic [CB:0]   lsum, rsum;
    r = '0;
    if (c.opcode == tsi_pkg::OP_START) begin
      if (m.moving) begin
        r.status = tsi_pkg::ST_BUSY;
      end else begin
        lback = c.left_target < m.lpos;
        rback = c.right_target < m.rpos;
        ldist = lback ? m.lpos - c.left_target : c.left_target - m.lpos;
        rdist = rback ? m.rpos - c.right_target : c.right_target - m.rpos;
        if (ldist > cfg_max_move || rdist > cfg_max_move) begin
          r.status = tsi_pkg::ST_TOO_LARGE;
        end else if (ldist == '0 && rdist == '0) begin
          r.status = tsi_pkg::ST_NO_MOVE;
        end else begin
          r.status = tsi_pkg::ST_ACCEPTED;
          m.lgoal = c.left_target;
          m.rgoal = c.right_target;
          m.ldelta = ldist[CB-1:0];
          m.rdelta = rdist[CB-1:0];
          m.longest = (m.ldelta > m.rdelta) ? m.ldelta : m.rdelta;
          m.lacc = '0;
          m.racc = '0;
          m.iters = m.longest;
          m.wait_cnt = '0;
          m.delay = clamp_delay(c.step_delay);
          m.dir = {rback, lback};
          m.moving = 1'b1;
        end
      end
    end else if (m.moving) begin
      if (m.wait_cnt != '0) begin
        m.wait_cnt = m.wait_cnt - 1'b1;
      end else if (m.iters == '0) begin
        m.lpos = m.lgoal;
        m.rpos = m.rgoal;
        m.moving = 1'b0;
        r.move_done = 1'b1;
      end else begin
        // one dda iteration per axis, the sum may exceed the counter width
        lsum = {1'b0, m.lacc} + {1'b0, m.ldelta};
        rsum = {1'b0, m.racc} + {1'b0, m.rdelta};
        r.left_step = lsum >= {1'b0, m.longest};
        r.right_step = rsum >= {1'b0, m.longest};
        m.lacc = r.left_step ? CB'(lsum - m.longest) : lsum[CB-1:0];
        m.racc = r.right_step ? CB'(rsum - m.longest) : rsum[CB-1:0];
        m.iters = m.iters - 1'b1;
        m.wait_cnt = m.delay - 1'b1;
      end
    end
    r.left_backward = m.dir[0];
    r.right_backward = m.dir[1];
    r.busy_res = m.moving;
    return r;
  endfunction

  function automatic int ticks_to_finish(motion_t m);
    if (!m.moving) return 0;
    return int'(m.wait_cnt) + int'(m.iters) * int'(m.delay) + 1;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (bad_fields < 10)
        $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
      bad_fields++;
    end
  endfunction

  // ---------------------------------------------------------------- planning

  function automatic void queue_cmd(tsi_pkg::cmd_t c);
    void'(interpolate_item(plan_motion, c));
    cmd_backlog.push_back(c);
    queued_cmds++;
  endfunction

  function automatic tsi_pkg::cmd_t random_cmd(tsi_pkg::opcode_t op);
    tsi_pkg::cmd_t c;
    c.opcode = op;
    c.left_target = PB'($urandom);
    c.right_target = PB'($urandom);
    c.step_delay = DB'($urandom);
    return c;
  endfunction

  function automatic tsi_pkg::cmd_t start_cmd(logic [PB-1:0] lt, logic [PB-1:0] rt,
                                              logic [DB-1:0] d);
    tsi_pkg::cmd_t c;
    c.opcode = tsi_pkg::OP_START;
    c.left_target = lt;
    c.right_target = rt;
    c.step_delay = d;
    return c;
  endfunction

  // ticks until the planned move has finished
  function automatic void drain_plan();
    repeat (ticks_to_finish(plan_motion)) queue_cmd(random_cmd(tsi_pkg::OP_TICK));
  endfunction

  function automatic logic [PB-1:0] axis_target(logic [PB-1:0] pos, int mag);
    if (mag == 0) return pos;
    if ($urandom_range(0, 1) == 1 && int'(pos) >= mag) return pos - PB'(mag);
    if (int'(pos) + mag <= (1 << PB) - 1) return pos + PB'(mag);
    return pos - PB'(mag);
  endfunction

  function automatic int pick_mag(int lim);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return lim;
      default: return $urandom_range(1, lim);
    endcase
  endfunction

  // mostly complete moves, mixed at random with refused starts and raw noise
  function automatic void random_phase(int budget, int cap);
    int            first, kind, span, lim, mag;
    tsi_pkg::cmd_t c;
    motion_t       trial;
    tsi_pkg::res_t r;
    first = queued_cmds;
    while (queued_cmds - first < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        drain_plan();
        c = random_cmd(tsi_pkg::OP_START);
        c.step_delay = ($urandom_range(0, 9) < 3) ? DB'($urandom_range(0, 255))
                                                   : DB'($urandom_range(0, 4));
        span = cap / int'(clamp_delay(c.step_delay));
        if (span < 1) span = 1;
        lim = (int'(cfg_max_move) < span) ? int'(cfg_max_move) : span;
        c.left_target = axis_target(plan_motion.lpos, pick_mag(lim));
        c.right_target = axis_target(plan_motion.rpos, pick_mag(lim));
        queue_cmd(c);
        repeat (ticks_to_finish(plan_motion)) begin
          if ($urandom_range(0, 19) == 0) queue_cmd(random_cmd(tsi_pkg::OP_START));
          queue_cmd(random_cmd(tsi_pkg::OP_TICK));
        end
        repeat ($urandom_range(0, 2)) queue_cmd(random_cmd(tsi_pkg::OP_TICK));
      end else if (kind < 85) begin
        c = random_cmd(tsi_pkg::OP_START);
        if ($urandom_range(0, 2) != 0) begin
          c.left_target = plan_motion.lpos;
          c.right_target = plan_motion.rpos;
          if ($urandom_range(0, 1) == 1) begin
            // just past the limit on one axis
            mag = int'(cfg_max_move) + 1 + $urandom_range(0, 2);
            if ($urandom_range(0, 1) == 1)
              c.left_target = axis_target(plan_motion.lpos, mag);
            else
              c.right_target = axis_target(plan_motion.rpos, mag);
          end
        end
        queue_cmd(c);
      end else begin
        c = random_cmd($urandom_range(0, 1) ? tsi_pkg::OP_TICK : tsi_pkg::OP_START);
        trial = plan_motion;
        r = interpolate_item(trial, c);
        if (r.status == tsi_pkg::ST_ACCEPTED && ticks_to_finish(trial) > 4 * cap)
          c.opcode = tsi_pkg::OP_TICK;
        queue_cmd(c);
      end
    end
    drain_plan();
  endfunction

  // ------------------------------------------------------------ config port

  task automatic cfg_access(input tsi_pkg::reg_index_t idx, input logic wr,
                            input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr) check_field("register readback", data, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reconfigure(input logic [MB-1:0] move_limit,
                             input logic [DB-1:0] lo, input logic [DB-1:0] hi);
    while (cmd_backlog.size() != 0 || motor_results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_access(tsi_pkg::REG_MAX_MOVE_STEPS, 1'b1, 32'(move_limit));
    cfg_access(tsi_pkg::REG_MIN_STEP_DELAY, 1'b1, 32'(lo));
    cfg_access(tsi_pkg::REG_MAX_STEP_DELAY, 1'b1, 32'(hi));
    cfg_max_move = move_limit;
    cfg_min_delay = lo;
    cfg_max_delay = hi;
    cfg_access(tsi_pkg::REG_MAX_MOVE_STEPS, 1'b0, 32'(move_limit));
    cfg_access(tsi_pkg::REG_MIN_STEP_DELAY, 1'b0, 32'(lo));
    cfg_access(tsi_pkg::REG_MAX_STEP_DELAY, 1'b0, 32'(hi));
  endtask

  // ----------------------------------------------------------------- driver

  always @(posedge clk) begin : cmd_source
    tsi_pkg::cmd_t sent;
    bit            offer;
    if (!rst_n) begin
      cmd_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        sent = cmd_backlog.pop_front();
        motor_results_due.push_back(interpolate_item(live_motion, sent));
        cmds_taken++;
      end
      // a command on offer stays until its transfer
      if (!cmd_ch.valid || cmd_ch.ready) begin
        offer = 1'b0;
        if (src_gap > 0)
          src_gap--;
        else if (idle_on && !hold_off && $urandom_range(0, 7) == 0)
          src_gap = $urandom_range(0, 14);
        else
          offer = cmd_backlog.size() > 0;
        cmd_ch.valid <= offer;
        if (offer) begin
          cmd_ch.opcode <= cmd_backlog[0].opcode;
          cmd_ch.left_target <= cmd_backlog[0].left_target;
          cmd_ch.right_target <= cmd_backlog[0].right_target;
          cmd_ch.step_delay <= cmd_backlog[0].step_delay;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : res_sink
    tsi_pkg::res_t want;
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (motor_results_due.size() == 0) begin
          if (bad_fields < 10) $display("mismatch at %0t: result with nothing expected", $time);
          bad_fields++;
        end else begin
          want = motor_results_due.pop_front();
          check_field("left_step", want.left_step, res_ch.left_step);
          check_field("right_step", want.right_step, res_ch.right_step);
          check_field("left_backward", want.left_backward, res_ch.left_backward);
          check_field("right_backward", want.right_backward, res_ch.right_backward);
          check_field("busy_res", want.busy_res, res_ch.busy_res);
          check_field("move_done", want.move_done, res_ch.move_done);
          check_field("status", want.status, res_ch.status);
        end
      end
      if (hold_off) begin
        res_ch.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        res_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        snk_gap = $urandom_range(0, 14);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver stall so the block backs up into its input
  initial begin
    while (cmds_taken < 100) @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  // ------------------------------------------------------------- sequencing

  initial begin
    rst_n = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = tsi_pkg::OP_TICK;
    cmd_ch.left_target = '0;
    cmd_ch.right_target = '0;
    cmd_ch.step_delay = '0;
    res_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    live_motion = '{default: '0};
    plan_motion = '{default: '0};
    cfg_max_move = tsi_pkg::MAX_MOVE_RESET;
    cfg_min_delay = tsi_pkg::MIN_DELAY_RESET;
    cfg_max_delay = tsi_pkg::MAX_DELAY_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    cfg_access(tsi_pkg::REG_MAX_MOVE_STEPS, 1'b0, 32'(tsi_pkg::MAX_MOVE_RESET));
    cfg_access(tsi_pkg::REG_MIN_STEP_DELAY, 1'b0, 32'(tsi_pkg::MIN_DELAY_RESET));
    cfg_access(tsi_pkg::REG_MAX_STEP_DELAY, 1'b0, 32'(tsi_pkg::MAX_DELAY_RESET));

    // tick while idle, no movement, too large on each axis, delay below the
    // clamp, start while busy, a backward move with one axis standing still
    queue_cmd(random_cmd(tsi_pkg::OP_TICK));
    queue_cmd(start_cmd(0, 0, 5));
    queue_cmd(start_cmd(5001, 0, 9));
    queue_cmd(start_cmd(0, '1, '1));
    queue_cmd(start_cmd(2, 1, 0));
    queue_cmd(start_cmd('1, 24'hABCDEF, 8'h80));
    drain_plan();
    queue_cmd(start_cmd(0, 1, 4));
    drain_plan();

    reconfigure(16'hFFFF, 1, 255);
    random_phase(300, 40);

    // one step per move and the longest delay
    reconfigure(1, 255, 255);
    random_phase(300, 60);

    // min above max, so max wins
    reconfigure(16, 200, 2);
    random_phase(250, 40);

    reconfigure(16'hFFFF, 1, 1);
    idle_on <= 1'b0;
    random_phase(150, 40);

    // deltas at the edge of the step counter width; the long move is only
    // run for its first iterations, where the sums overflow the counters
    queue_cmd(start_cmd(axis_target(plan_motion.lpos, 65536), plan_motion.rpos, 7));
    queue_cmd(start_cmd(axis_target(plan_motion.lpos, 65535),
                        axis_target(plan_motion.rpos, $urandom_range(32768, 65534)), 0));
    repeat (100) queue_cmd(random_cmd(tsi_pkg::OP_TICK));

    while (cmd_backlog.size() != 0 || motor_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (bad_fields == 0 && motor_results_due.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
